>>> rtl/crpg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crpg_pkg
// Shared types and constants of the constrained random password generator.
// ----------------------------------------------------------------------------
package crpg_pkg;

    localparam int MAX_LEN = 32;
    localparam logic [15:0] LFSR_RESET = 16'hACE1;
    localparam logic [7:0] DASH_CHAR = 8'd45;

    typedef enum logic [2:0] {
        CFG_MIN_LETTERS = 3'd0,
        CFG_MAX_LETTERS = 3'd1,
        CFG_MIN_DIGITS  = 3'd2,
        CFG_MAX_DIGITS  = 3'd3,
        CFG_MIN_SPECIAL = 3'd4,
        CFG_MAX_SPECIAL = 3'd5,
        CFG_TOTAL_LEN   = 3'd6,
        CFG_GROUP_SIZE  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic        load_seed;
        logic [15:0] seed_value;
    } req_t;

    typedef struct packed {
        logic [7:0] character;
        logic       last_item;
        logic       rejected;
    } res_t;

    // one lfsr step: shift right, xor of taps 0,2,3,5 into bit 15
    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        lfsr_next = {s[0] ^ s[2] ^ s[3] ^ s[5], s[15:1]};
    endfunction

    function automatic logic [7:0] letter_char(input logic [5:0] k);
        letter_char = (k < 6'd26) ? 8'd65 + {2'b0, k} : 8'd71 + {2'b0, k};
    endfunction

    function automatic logic [7:0] digit_char(input logic [5:0] k);
        digit_char = 8'd48 + {2'b0, k};
    endfunction

    function automatic logic [7:0] special_char(input logic [5:0] k);
        if (k < 6'd15)
            special_char = 8'd33 + {2'b0, k};
        else if (k < 6'd22)
            special_char = 8'd43 + {2'b0, k};
        else
            special_char = 8'd72 + {2'b0, k};
    endfunction

endpackage
`default_nettype wire

>>> rtl/constrained_random_password_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// constrained_random_password_generator_core
// LFSR driven password generator: draws class counts, fills, shuffles and
// streams the characters with dash separators, one shared modulo unit.
// ----------------------------------------------------------------------------
//  channel | ports              | direction | carries
//  s_      | s_valid/s_ready    | in        | req_t (load_seed, seed_value)
//  m_      | m_valid/m_ready    | out       | res_t (character, last, rejected)
//  cfg     | cfg_valid/cfg_ready| in        | cfg_index, cfg_data
//
// Each modulo (lfsr mod m) runs through one shared restoring remainder unit,
// and each shuffle step adds a swap. Reset is synchronous active low and sets
// the lfsr, the configuration registers and the control state; the buffer is
// not cleared. Output stalls hold the sequencer; a new request is taken once
// the last result of the current one sits in the output register.
module constrained_random_password_generator_core (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  crpg_pkg::req_t       s_data,
    output logic                 m_valid,
    input  wire                  m_ready,
    output crpg_pkg::res_t       m_data,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [2:0]           cfg_index,
    input  wire  [5:0]           cfg_data
);
    import crpg_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DRAW   = 9'b000000010,
        ST_CHECK  = 9'b000000100,
        ST_FILL   = 9'b000001000,
        ST_SHUF   = 9'b000010000,
        ST_SWAP   = 9'b000100000,
        ST_READ   = 9'b001000000,
        ST_EMIT   = 9'b010000000,
        ST_DASH   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [5:0] min_l_reg, max_l_reg, min_d_reg, max_d_reg;
    logic [5:0] min_s_reg, max_s_reg, total_reg, group_reg;

    logic [15:0] lfsr_reg;
    logic [7:0]  buf_mem [0:MAX_LEN-1];

    // request state
    logic        draw_sel_reg;       // 0 letters, 1 digits
    logic [5:0]  letters_reg, digits_reg;
    logic [5:0]  n_reg;              // total length
    logic [5:0]  idx_reg;            // fill/shuffle/emit position
    logic [5:0]  grp_reg;
    logic [4:0]  j_reg;
    logic [7:0]  tmp_i_reg;
    logic        swap_ph_reg;
    logic        res_valid_reg;
    res_t        res_reg;
    logic [7:0]  rd_reg;

    // shared remainder unit
    logic        div_busy_reg, div_done_reg;
    logic [4:0]  div_cnt_reg;
    logic [15:0] div_q_reg;
    logic [6:0]  div_r_reg, div_m_reg;
    logic        div_start;
    logic [6:0]  div_m_in;
    logic [7:0]  div_trial;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = res_valid_reg;
    assign m_data    = res_reg;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_l_reg <= 6'd0; max_l_reg <= 6'd8;
            min_d_reg <= 6'd0; max_d_reg <= 6'd8;
            min_s_reg <= 6'd0; max_s_reg <= 6'd8;
            total_reg <= 6'd16; group_reg <= 6'd4;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_MIN_LETTERS: min_l_reg <= cfg_data;
                CFG_MAX_LETTERS: max_l_reg <= cfg_data;
                CFG_MIN_DIGITS:  min_d_reg <= cfg_data;
                CFG_MAX_DIGITS:  max_d_reg <= cfg_data;
                CFG_MIN_SPECIAL: min_s_reg <= cfg_data;
                CFG_MAX_SPECIAL: max_s_reg <= cfg_data;
                CFG_TOTAL_LEN:   total_reg <= cfg_data;
                CFG_GROUP_SIZE:  group_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // restoring remainder: lfsr mod m, one quotient bit per cycle
    assign div_trial = {div_r_reg, div_q_reg[15]} - {1'b0, div_m_reg};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_busy_reg <= 1'b0;
            div_done_reg <= 1'b0;
        end else begin
            div_done_reg <= 1'b0;
            if (div_start) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'd0;
                div_q_reg    <= lfsr_reg;
                div_r_reg    <= 7'd0;
                div_m_reg    <= div_m_in;
            end else if (div_busy_reg) begin
                div_q_reg <= {div_q_reg[14:0], 1'b0};
                div_r_reg <= div_trial[7] ? {div_r_reg[5:0], div_q_reg[15]}
                                          : div_trial[6:0];
                div_cnt_reg <= div_cnt_reg + 5'd1;
                if (div_cnt_reg == 5'd15) begin
                    div_busy_reg <= 1'b0;
                    div_done_reg <= 1'b1;
                end
            end
        end
    end

    // derived values
    logic [5:0] tot_clamp;
    logic [6:0] rng_l, rng_d;
    logic signed [7:0] spec_cnt;
    logic [5:0] fill_k;
    logic [5:0] rem6;
    assign rem6 = div_r_reg[5:0];
    assign tot_clamp = (total_reg == 6'd0) ? 6'd1 :
                       (total_reg > 6'd32) ? 6'd32 : total_reg;
    assign rng_l = {1'b0, max_l_reg} - {1'b0, min_l_reg} + 7'd1;
    assign rng_d = {1'b0, max_d_reg} - {1'b0, min_d_reg} + 7'd1;
    assign spec_cnt = $signed({2'b0, tot_clamp}) - $signed({2'b0, letters_reg})
                    - $signed({2'b0, digits_reg});
    assign fill_k = idx_reg;
    logic [5:0] ld_sum;
    assign ld_sum = letters_reg + digits_reg;

    // modulus and start for the shared unit
    // a count range of one value or an inverted one still steps through a modulus of one
    logic need_div;
    always_comb begin
        div_m_in = 7'd1;
        if (state_reg == ST_DRAW) begin
            if (draw_sel_reg)
                div_m_in = (max_d_reg > min_d_reg) ? rng_d : 7'd1;
            else
                div_m_in = (max_l_reg > min_l_reg) ? rng_l : 7'd1;
        end else if (state_reg == ST_FILL)
            div_m_in = (fill_k < letters_reg) ? 7'd52 :
                       (fill_k < ld_sum) ? 7'd10 : 7'd25;
        else
            div_m_in = {1'b0, idx_reg} + 7'd1;
    end
    assign need_div = (state_reg == ST_DRAW || state_reg == ST_FILL
                       || state_reg == ST_SHUF);

    logic started_reg;
    assign div_start = need_div && !started_reg && !div_busy_reg && !div_done_reg;

    // sequencer
    logic [7:0] fill_ch;
    always_comb begin
        if (fill_k < letters_reg) fill_ch = letter_char(rem6);
        else if (fill_k < ld_sum) fill_ch = digit_char(rem6);
        else                      fill_ch = special_char(rem6);
    end

    logic out_free;
    assign out_free = !res_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            lfsr_reg      <= LFSR_RESET;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && m_ready) res_valid_reg <= 1'b0;
            if (div_start) started_reg <= 1'b1;
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_data.load_seed) lfsr_reg <= s_data.seed_value;
                        draw_sel_reg <= 1'b0;
                        state_reg    <= ST_DRAW;
                    end
                end
                ST_DRAW: begin
                    // counts use the state before the step
                    if (div_done_reg) begin
                        started_reg <= 1'b0;
                        lfsr_reg    <= lfsr_next(lfsr_reg);
                        if (!draw_sel_reg) begin
                            letters_reg  <= (max_l_reg <= min_l_reg) ? min_l_reg
                                            : min_l_reg + rem6;
                            draw_sel_reg <= 1'b1;
                        end else begin
                            digits_reg <= (max_d_reg <= min_d_reg) ? min_d_reg
                                          : min_d_reg + rem6;
                            state_reg  <= ST_CHECK;
                        end
                    end
                end
                ST_CHECK: begin
                    if (out_free) begin
                        if (spec_cnt < $signed({2'b0, min_s_reg})
                            || spec_cnt > $signed({2'b0, max_s_reg})) begin
                            res_reg       <= '{character: 8'd0, last_item: 1'b1,
                                               rejected: 1'b1};
                            res_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end else begin
                            n_reg     <= tot_clamp;
                            idx_reg   <= 6'd0;
                            lfsr_reg  <= lfsr_next(lfsr_reg);
                            state_reg <= ST_FILL;
                        end
                    end
                end
                ST_FILL: begin
                    if (div_done_reg) begin
                        started_reg <= 1'b0;
                        buf_mem[idx_reg[4:0]] <= fill_ch;
                        if (idx_reg + 6'd1 == n_reg) begin
                            idx_reg <= n_reg - 6'd1;
                            if (n_reg == 6'd1) begin
                                idx_reg   <= 6'd0;
                                grp_reg   <= 6'd0;
                                state_reg <= ST_READ;
                            end else begin
                                lfsr_reg  <= lfsr_next(lfsr_reg);
                                state_reg <= ST_SHUF;
                            end
                        end else begin
                            idx_reg  <= idx_reg + 6'd1;
                            lfsr_reg <= lfsr_next(lfsr_reg);
                        end
                    end
                end
                ST_SHUF: begin
                    if (div_done_reg) begin
                        started_reg <= 1'b0;
                        j_reg       <= rem6[4:0];
                        swap_ph_reg <= 1'b0;
                        state_reg   <= ST_SWAP;
                    end
                end
                ST_SWAP: begin
                    // latch entry i, then exchange
                    if (!swap_ph_reg) begin
                        tmp_i_reg   <= buf_mem[idx_reg[4:0]];
                        swap_ph_reg <= 1'b1;
                    end else begin
                        // swapping an entry with itself changes nothing
                        if (j_reg != idx_reg[4:0]) begin
                            buf_mem[idx_reg[4:0]] <= buf_mem[j_reg];
                            buf_mem[j_reg]        <= tmp_i_reg;
                        end
                        if (idx_reg == 6'd1) begin
                            idx_reg   <= 6'd0;
                            grp_reg   <= 6'd0;
                            state_reg <= ST_READ;
                        end else begin
                            idx_reg   <= idx_reg - 6'd1;
                            lfsr_reg  <= lfsr_next(lfsr_reg);
                            state_reg <= ST_SHUF;
                        end
                    end
                end
                ST_READ: begin
                    rd_reg    <= buf_mem[idx_reg[4:0]];
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        res_reg <= '{character: rd_reg,
                                     last_item: (idx_reg + 6'd1 == n_reg),
                                     rejected: 1'b0};
                        res_valid_reg <= 1'b1;
                        if (idx_reg + 6'd1 == n_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (grp_reg + 6'd1 == group_reg) begin
                            grp_reg   <= 6'd0;
                            state_reg <= ST_DASH;
                        end else begin
                            grp_reg   <= grp_reg + 6'd1;
                            idx_reg   <= idx_reg + 6'd1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_DASH: begin
                    if (out_free) begin
                        res_reg <= '{character: DASH_CHAR, last_item: 1'b0,
                                     rejected: 1'b0};
                        res_valid_reg <= 1'b1;
                        idx_reg       <= idx_reg + 6'd1;
                        state_reg     <= ST_READ;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // a rejected result is always the last one
    a_rej_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.rejected) |-> m_data.last_item)
        else $error("reject without last");
    // no request taken during a fill or a shuffle swap
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL || state_reg == ST_SWAP) |-> !s_ready)
        else $error("ready while busy");
    // remainder unit result stays below its modulus
    a_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done_reg |-> (div_r_reg < div_m_reg))
        else $error("remainder out of range");
`endif

endmodule
`default_nettype wire
